### sv/pdrr_pkg.sv
// Package for the packet deframer and row-pair realigner.
// Holds shared widths, the group map type and the pair position struct.
// No dependencies.
`default_nettype none

package pdrr_pkg;

  localparam int unsigned GroupW = 3;
  localparam int unsigned PhaseW = 2;
  localparam int unsigned PairW  = 6;
  localparam int unsigned WordW  = 3;
  localparam int unsigned PktW   = 5;
  localparam int unsigned RowW   = 10;
  localparam int unsigned MapW   = 48;
  localparam int unsigned NumGroupSlots = 8;

  typedef logic [GroupW-1:0] group_t;
  typedef logic [PhaseW-1:0] phase_t;
  typedef logic [PairW-1:0]  pair_t;
  typedef logic [RowW-1:0]   row_t;

  typedef logic [15:0][GroupW-1:0] gmap_t;

  typedef enum logic {
    CfgMapLow  = 1'b0,
    CfgMapHigh = 1'b1
  } cfg_index_e;

  typedef struct packed {
    group_t group;
    phase_t phase;
    pair_t  pair;
  } pdrr_pos_t;

endpackage

`default_nettype wire

### sv/pdrr_index.sv
// Row index calculator: first global row of the current row pair.
// Depends on pdrr_pkg for the position struct and the row width.
`default_nettype none

module pdrr_index
  import pdrr_pkg::*;
#(
  parameter int unsigned SEQ_LEN           = 32,
  parameter int unsigned QUERIES_PER_GROUP = 4
) (
  input  pdrr_pos_t pos_i,
  output row_t      row_o
);

  localparam logic [6:0]  SeqLen7  = 7'(SEQ_LEN);
  localparam logic [13:0] SeqLen14 = 14'(SEQ_LEN);
  localparam logic [6:0]  Qpg7     = 7'(QUERIES_PER_GROUP);

  logic [6:0]  row_in_pkt;
  logic        q_in;
  logic [6:0]  seq;
  logic [6:0]  q_head;
  logic [13:0] full_row;

  always_comb begin
    row_in_pkt = {pos_i.pair, 1'b0};
    q_in       = (row_in_pkt >= SeqLen7);
    seq        = q_in ? (row_in_pkt - SeqLen7) : row_in_pkt;
    q_head     = 7'(7'(pos_i.group) * Qpg7) + {4'd0, pos_i.phase, 1'b0} + {6'd0, q_in};
    full_row   = 14'(14'(q_head) * SeqLen14) + {7'd0, seq};
    row_o      = full_row[RowW-1:0];
  end

endmodule

`default_nettype wire

### sv/packet_deframer_row_pair_realigner_top.sv
// Top level of the packet deframer and row-pair realigner.
// Depends on pdrr_pkg and instantiates pdrr_index.
//
// Usage: stream words enter on the input channel (in_valid_i, in_ready_o,
// word_low_i, word_high_i). The first word of each packet is a header and
// yields no transfer on the output channel. Each later word yields one
// realigned payload word with its row pair index, position and pair end flag.
// The result of an input transfer is registered in the output register.
// Throughput is one word per cycle while the receiver takes each result:
// all the work of a word is done in one pass of logic between the state
// registers and the output register, and a new word is taken while the
// output register is being drained. When the receiver stalls, the held
// result stays in the output register and in_ready_o drops until taken.
// Reset clears the group map, all counters and the group packet counts, and
// the block then expects a header. The group map must be written through the
// cfg port only while the block is idle; the block does not enforce this.
`default_nettype none

module packet_deframer_row_pair_realigner_top
  import pdrr_pkg::*;
#(
  parameter int unsigned SEQ_LEN           = 32,
  parameter int unsigned KV_GROUPS         = 8,
  parameter int unsigned QUERIES_PER_GROUP = 4,
  parameter int unsigned SLICE_WIDTH       = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [47:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] word_low_i,
  input  logic [63:0] word_high_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] payload_low_o,
  output logic [63:0] payload_high_o,
  output logic [9:0]  pair_row_index_o,
  output logic [2:0]  word_of_pair_o,
  output logic        pair_done_o
);

  localparam int unsigned WordsPerPair =
      ((SLICE_WIDTH / 4) < 1) ? 1 : (SLICE_WIDTH / 4);
  localparam int unsigned PacketsPerBatch = KV_GROUPS * (QUERIES_PER_GROUP / 2);
  localparam logic [WordW-1:0] LastWord = WordW'(WordsPerPair - 1);
  localparam logic [PairW-1:0] LastPair = PairW'(SEQ_LEN - 1);
  localparam logic [PktW-1:0]  LastPkt  = PktW'(PacketsPerBatch - 1);

  gmap_t            map_lo_q, map_hi_q;
  logic [95:0]      tail_q, tail_d;
  logic             exp_hdr_q, exp_hdr_d;
  group_t           group_q, group_d;
  phase_t           phase_q, phase_d;
  phase_t [NumGroupSlots-1:0] seen_q, seen_d;
  logic [WordW-1:0] word_cnt_q, word_cnt_d;
  pair_t            pair_cnt_q, pair_cnt_d;
  logic [PktW-1:0]  pkt_cnt_q, pkt_cnt_d;

  logic             out_valid_q, out_valid_d;
  logic [127:0]     payload_q, payload_d;
  row_t             row_q;
  logic [WordW-1:0] wop_q;
  logic             done_q, done_d;

  logic             in_xfer;
  group_t           hdr_group;
  logic [4:0]       hdr_id;
  pdrr_pos_t        pos;
  row_t             row_now;
  logic             last_word;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign hdr_id    = word_low_i[4:0];
  assign hdr_group = hdr_id[4] ? map_hi_q[hdr_id[3:0]] : map_lo_q[hdr_id[3:0]];

  assign pos.group = group_q;
  assign pos.phase = phase_q;
  assign pos.pair  = pair_cnt_q;

  pdrr_index #(
    .SEQ_LEN          (SEQ_LEN),
    .QUERIES_PER_GROUP(QUERIES_PER_GROUP)
  ) u_index (
    .pos_i(pos),
    .row_o(row_now)
  );

  assign last_word = (word_cnt_q == LastWord);

  always_comb begin
    tail_d      = tail_q;
    exp_hdr_d   = exp_hdr_q;
    group_d     = group_q;
    phase_d     = phase_q;
    seen_d      = seen_q;
    word_cnt_d  = word_cnt_q;
    pair_cnt_d  = pair_cnt_q;
    pkt_cnt_d   = pkt_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    payload_d   = {word_low_i[31:0], tail_q};
    done_d      = last_word;
    if (in_xfer) begin
      tail_d = {word_high_i, word_low_i[63:32]};
      if (exp_hdr_q) begin
        out_valid_d       = 1'b0;
        exp_hdr_d         = 1'b0;
        group_d           = hdr_group;
        phase_d           = seen_q[hdr_group];
        seen_d[hdr_group] = seen_q[hdr_group] + 2'd1;
        word_cnt_d        = '0;
        pair_cnt_d        = '0;
      end else begin
        out_valid_d = 1'b1;
        if (last_word) begin
          word_cnt_d = '0;
          if (pair_cnt_q == LastPair) begin
            pair_cnt_d = '0;
            exp_hdr_d  = 1'b1;
            if (pkt_cnt_q == LastPkt) begin
              pkt_cnt_d = '0;
              seen_d    = '0;
            end else begin
              pkt_cnt_d = pkt_cnt_q + 1'b1;
            end
          end else begin
            pair_cnt_d = pair_cnt_q + 1'b1;
          end
        end else begin
          word_cnt_d = word_cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_lo_q    <= '0;
      map_hi_q    <= '0;
      tail_q      <= '0;
      exp_hdr_q   <= 1'b1;
      group_q     <= '0;
      phase_q     <= '0;
      seen_q      <= '0;
      word_cnt_q  <= '0;
      pair_cnt_q  <= '0;
      pkt_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_e'(cfg_index_i))
          CfgMapLow:  map_lo_q <= cfg_wdata_i;
          CfgMapHigh: map_hi_q <= cfg_wdata_i;
          default:    map_lo_q <= map_lo_q;
        endcase
      end
      tail_q      <= tail_d;
      exp_hdr_q   <= exp_hdr_d;
      group_q     <= group_d;
      phase_q     <= phase_d;
      seen_q      <= seen_d;
      word_cnt_q  <= word_cnt_d;
      pair_cnt_q  <= pair_cnt_d;
      pkt_cnt_q   <= pkt_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && !exp_hdr_q) begin
      payload_q <= payload_d;
      row_q     <= row_now;
      wop_q     <= word_cnt_q;
      done_q    <= done_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign payload_low_o    = payload_q[63:0];
  assign payload_high_o   = payload_q[127:64];
  assign pair_row_index_o = row_q;
  assign word_of_pair_o   = wop_q;
  assign pair_done_o      = done_q;

`ifndef ASSERT_OFF
  a_stall_holds_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled without a pending result");

  a_header_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && exp_hdr_q) |=> !out_valid_o)
    else $error("header transfer produced a result");

  a_word_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_cnt_q <= LastWord)
    else $error("word counter beyond pair length");

  a_pair_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_cnt_q <= LastPair)
    else $error("pair counter beyond packet length");

  a_done_matches_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pair_done_o == (word_of_pair_o == LastWord)))
    else $error("pair end flag disagrees with word position");
`endif

endmodule

`default_nettype wire
